### rtl/log_delta_sample_decoder_unit_defines.svh
// Assertion macros for the log delta sample decoder.
`ifndef LOG_DELTA_SAMPLE_DECODER_UNIT_DEFINES_SVH
`define LOG_DELTA_SAMPLE_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define LDSD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset.
`define LDSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/ldsd_pkg.sv
`default_nettype none
package ldsd_pkg;

    localparam int unsigned CODE_W   = 8;
    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned SPA_W    = 16;
    localparam int unsigned RUN_W    = 8;
    localparam int unsigned CFG_W    = 16;

    // Request type codes
    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    // Value given for a blanked sample
    localparam logic [VALUE_W-1:0] BLANK_VALUE = 32'hFFFF_8000;

    typedef struct packed {
        logic               req_type;
        logic [CODE_W-1:0]  code;
        logic [VALUE_W-1:0] start_value;
    } t_item;

endpackage
`default_nettype wire

### rtl/ldsd_delta.sv
`default_nettype none
module ldsd_delta
    import ldsd_pkg::*;
(
    input  wire logic [CODE_W-1:0]  i_code,
    output logic      [VALUE_W-1:0] o_delta
);

    // Hidden leading part and scale (as a shift) per shift code
    localparam logic [4:0] HIDDEN [16] = '{5'd8, 5'd8, 5'd8, 5'd8, 5'd8, 5'd8, 5'd8, 5'd8,
                                          5'd8, 5'd8, 5'd24, 5'd16, 5'd24, 5'd16, 5'd8,
                                          5'd0};
    localparam logic [3:0] SHIFT [16] = '{4'd12, 4'd11, 4'd10, 4'd9, 4'd8, 4'd7, 4'd6,
                                         4'd5, 4'd4, 4'd3, 4'd1, 4'd1, 4'd0, 4'd0, 4'd0,
                                         4'd0};

    logic [6:0]         w_k;
    logic [3:0]         w_s;
    logic [16:0]        w_mag;
    logic [VALUE_W-1:0] w_ext;

    always_comb begin
        // positive half uses the low seven bits, negative half counts down from 128
        w_k   = i_code[7] ? i_code[6:0] : 7'(9'd128 - {1'b0, i_code});
        w_s   = 4'd15 - w_k[6:3];
        w_mag = (17'(HIDDEN[w_s]) + 17'(w_k[2:0])) << SHIFT[w_s];
        w_ext = {{(VALUE_W-17){1'b0}}, w_mag};
        if (i_code == '0) begin
            o_delta = '0;
        end else if (i_code[7]) begin
            o_delta = w_ext;
        end else begin
            o_delta = '0 - w_ext;
        end
    end

endmodule
`default_nettype wire

### rtl/ldsd_seq.sv
`default_nettype none
`include "log_delta_sample_decoder_unit_defines.svh"
module ldsd_seq
    import ldsd_pkg::*;
#(
    parameter int unsigned AXIS_COUNT_BITS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire t_item              i_item,
    input  wire logic [SPA_W-1:0]   i_samples_per_axis,
    input  wire logic [RUN_W-1:0]   i_blank_run_length,
    output logic                    o_advance,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [VALUE_W-1:0]      o_sample_value,
    output logic                    o_is_blank,
    output logic                    o_axis_end
);

    localparam int unsigned CW = (AXIS_COUNT_BITS + 1 > SPA_W + 1) ?
                                 AXIS_COUNT_BITS + 1 : SPA_W + 1;

    logic [VALUE_W-1:0]         r_sum, n_sum;
    logic [RUN_W-1:0]           r_blank_cd, n_blank_cd;
    logic [AXIS_COUNT_BITS-1:0] r_axis_pos, n_axis_pos;
    logic                       r_out_valid, n_out_valid;
    logic [VALUE_W-1:0]         r_sample_value;
    logic                       r_is_blank, r_axis_end;

    logic [VALUE_W-1:0] w_delta;
    logic               w_sample, w_blank, w_end;
    logic [SPA_W-1:0]   w_spa;
    logic [RUN_W-1:0]   w_run;
    logic [CW-1:0]      w_next;

    ldsd_delta u_delta (
        .i_code  (i_item.code),
        .o_delta (w_delta)
    );

    always_comb begin
        w_sample  = (i_item.req_type == REQ_SAMPLE);
        // a load moves no result, so it need not wait for the output slot
        o_advance = i_valid && (!w_sample || !r_out_valid || i_out_ready);

        w_spa  = (i_samples_per_axis == '0) ? SPA_W'(1) : i_samples_per_axis;
        w_run  = (i_blank_run_length == '0) ? RUN_W'(1) : i_blank_run_length;
        w_next = CW'(r_axis_pos) + CW'(1);
        w_end  = (w_next >= CW'(w_spa)) || (&r_axis_pos);
        w_blank = (r_blank_cd != '0) || (i_item.code == '0);

        n_sum      = r_sum;
        n_blank_cd = r_blank_cd;
        n_axis_pos = r_axis_pos;
        if (o_advance) begin
            if (!w_sample) begin
                n_sum      = i_item.start_value;
                n_blank_cd = '0;
                n_axis_pos = '0;
            end else begin
                n_sum = r_sum + w_delta;
                if (r_blank_cd != '0) begin
                    n_blank_cd = r_blank_cd - RUN_W'(1);
                end else if (i_item.code == '0) begin
                    n_blank_cd = w_run - RUN_W'(1);
                end
                if (w_end) begin
                    n_axis_pos = '0;
                    n_blank_cd = '0;
                end else begin
                    n_axis_pos = w_next[AXIS_COUNT_BITS-1:0];
                end
            end
        end

        n_out_valid = r_out_valid;
        if (o_advance && w_sample) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_blank_cd  <= '0;
            r_axis_pos  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_sum       <= n_sum;
            r_blank_cd  <= n_blank_cd;
            r_axis_pos  <= n_axis_pos;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && w_sample) begin
            r_sample_value <= w_blank ? BLANK_VALUE : n_sum;
            r_is_blank     <= w_blank;
            r_axis_end     <= w_end;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_sample_value = r_sample_value;
    assign o_is_blank     = r_is_blank;
    assign o_axis_end     = r_axis_end;

    `LDSD_ASSERT_NEXT(a_load_clears, i_clk, i_rst_n, o_advance && !w_sample, (r_blank_cd == '0) && (r_axis_pos == '0), "load did not clear blank run and axis position")
    `LDSD_ASSERT_NEXT(a_end_restarts, i_clk, i_rst_n, o_advance && w_sample && w_end, (r_axis_pos == '0) && (r_blank_cd == '0) && r_axis_end, "axis end did not restart the axis")
    `LDSD_ASSERT_NEXT(a_load_no_result, i_clk, i_rst_n, o_advance && !w_sample && !r_out_valid, !r_out_valid, "load produced a result")
    `LDSD_ASSERT_NOW(a_blank_value, i_clk, i_rst_n, r_out_valid && r_is_blank, r_sample_value == BLANK_VALUE, "blanked sample carries a wrong value")

endmodule
`default_nettype wire

### rtl/log_delta_sample_decoder_unit.sv
// An accepted item passes the input register and then the result register of the decode stage.
// Throughput: one item per cycle while results are taken; an empty input register still fills.
// Load items produce no result and leave the input register without waiting on the result slot.
// Reset (i_rst_n low, synchronous): clears running sum, blank run and axis position,
// drops both pipeline valids, and sets samples per axis to 65535 and blank run to 1.
`default_nettype none
module log_delta_sample_decoder_unit
    import ldsd_pkg::*;
#(
    parameter int unsigned AXIS_COUNT_BITS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // configuration write port
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_index,
    input  wire logic [CFG_W-1:0]   i_cfg_data,
    // input channel
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic               i_req_type,
    input  wire logic [CODE_W-1:0]  i_code,
    input  wire logic [VALUE_W-1:0] i_start_value,
    // result channel
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [VALUE_W-1:0]      o_sample_value,
    output logic                    o_is_blank,
    output logic                    o_axis_end
);

    // Register indexes of the configuration port
    localparam logic CFG_SAMPLES_PER_AXIS = 1'b0;
    localparam logic CFG_BLANK_RUN_LENGTH = 1'b1;

    logic [SPA_W-1:0] r_samples_per_axis;
    logic [RUN_W-1:0] r_blank_run_length;

    // Input register: holds one item ahead of the decode stage
    logic  r_in_valid, n_in_valid;
    t_item r_item;
    logic  w_advance;

    // Take configuration writes whenever the enable is high; unknown bits are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_samples_per_axis <= SPA_W'(65535);
            r_blank_run_length <= RUN_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SAMPLES_PER_AXIS: r_samples_per_axis <= i_cfg_data[SPA_W-1:0];
                CFG_BLANK_RUN_LENGTH: r_blank_run_length <= i_cfg_data[RUN_W-1:0];
                default:              ;
            endcase
        end
    end

    // Ready while the input register is empty or about to hand its item on
    assign o_in_ready = !r_in_valid || w_advance;

    always_comb begin
        n_in_valid = r_in_valid;
        if (o_in_ready) begin
            n_in_valid = i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    // Capture the payload on acceptance; hold it otherwise
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item.req_type    <= i_req_type;
            r_item.code        <= i_code;
            r_item.start_value <= i_start_value;
        end
    end

    // Decode stage: table lookup, running sum, blank run and axis count, result register
    ldsd_seq #(
        .AXIS_COUNT_BITS (AXIS_COUNT_BITS)
    ) u_seq (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (r_in_valid),
        .i_item             (r_item),
        .i_samples_per_axis (r_samples_per_axis),
        .i_blank_run_length (r_blank_run_length),
        .o_advance          (w_advance),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_sample_value     (o_sample_value),
        .o_is_blank         (o_is_blank),
        .o_axis_end         (o_axis_end)
    );

endmodule
`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import ldsd_pkg::*;

    // Axis counter width handed to the block; the prediction uses the same width.
    localparam int unsigned AXIS_BITS = 16;
    // Register indexes of the configuration port.
    localparam logic REG_SAMPLES_PER_AXIS = 1'b0;
    localparam logic REG_BLANK_RUN_LENGTH = 1'b1;
    // Wait after the last result when draining, so that trailing loads have passed.
    localparam int DRAIN_CYCLES = 6;
    // Watchdog limit; the run sends roughly 2000 items.
    localparam int CYCLE_LIMIT = 400000;
    localparam int REPORT_LIMIT = 10;

    typedef struct {
        logic [VALUE_W-1:0] value;
        logic               blank;
        logic               last;
    } t_sample;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic               cfg_index = REG_SAMPLES_PER_AXIS;
    logic [CFG_W-1:0]   cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               req_type = REQ_LOAD;
    logic [CODE_W-1:0]  diff_code = '0;
    logic [VALUE_W-1:0] start_value = '0;
    logic               out_ready = 1'b0;
    wire                in_ready;
    wire                out_valid;
    wire [VALUE_W-1:0]  sample_value;
    wire                is_blank;
    wire                axis_end;

    // Copy of the block's state and registers, kept by the predictor.
    logic [VALUE_W-1:0]   running_sum;
    logic [RUN_W-1:0]     blank_left;
    logic [AXIS_BITS-1:0] axis_pos;
    logic [SPA_W-1:0]     spa_reg;
    logic [RUN_W-1:0]     run_reg;

    t_sample expected_samples[$];
    int      mismatches = 0;
    int      cycle_count = 0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;

    log_delta_sample_decoder_unit #(
        .AXIS_COUNT_BITS(AXIS_BITS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_req_type     (req_type),
        .i_code         (diff_code),
        .i_start_value  (start_value),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_sample_value (sample_value),
        .o_is_blank     (is_blank),
        .o_axis_end     (axis_end)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Stall the result side at the rate of the current phase.
    always @(posedge i_clk) begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Signed difference for one code from the logarithmic table.
    function automatic logic [VALUE_W-1:0] code_difference(logic [CODE_W-1:0] code);
        logic [7:0]  k;
        logic [3:0]  shift;
        logic [31:0] hidden;
        logic [31:0] scale;
        logic [31:0] mag;
        if (code == '0)
            return '0;
        // Upper half counts up from 128 as positive, lower half down from 128 as negative.
        k = code[7] ? (code - 8'd128) : (8'd128 - code);
        shift = 4'd15 - k[6:3];
        case (shift)
            4'd10:   begin hidden = 24; scale = 2; end
            4'd11:   begin hidden = 16; scale = 2; end
            4'd12:   begin hidden = 24; scale = 1; end
            4'd13:   begin hidden = 16; scale = 1; end
            4'd14:   begin hidden = 8;  scale = 1; end
            4'd15:   begin hidden = 0;  scale = 1; end
            default: begin
                hidden = 8;
                scale = 32'd4096 >> shift;
            end
        endcase
        mag = (hidden + 32'(k[2:0])) * scale;
        return code[7] ? mag : (32'd0 - mag);
    endfunction

    // Advance the predicted state by one accepted item; queue the sample it gives.
    function automatic void restore_sample(logic rtype, logic [CODE_W-1:0] code,
                                           logic [VALUE_W-1:0] load_value);
        logic                 blank;
        logic                 last;
        logic [AXIS_BITS:0]   next_pos;
        logic [SPA_W-1:0]     spa_eff;
        t_sample              s;
        if (rtype == REQ_LOAD) begin
            running_sum = load_value;
            blank_left = '0;
            axis_pos = '0;
            return;
        end
        // The sum keeps integrating even while the output is blanked.
        running_sum = running_sum + code_difference(code);
        if (blank_left != '0) begin
            // Zero codes inside a run do not restart it.
            blank = 1'b1;
            blank_left = blank_left - 1'b1;
        end else if (code == '0) begin
            blank = 1'b1;
            blank_left = (run_reg == '0) ? '0 : run_reg - 1'b1;
        end else begin
            blank = 1'b0;
        end
        spa_eff = (spa_reg == '0) ? SPA_W'(1) : spa_reg;
        next_pos = {1'b0, axis_pos} + 1'b1;
        last = (next_pos >= (AXIS_BITS + 1)'(spa_eff)) || next_pos[AXIS_BITS];
        if (last) begin
            // End of axis also cuts short any blank run.
            axis_pos = '0;
            blank_left = '0;
        end else begin
            axis_pos = next_pos[AXIS_BITS-1:0];
        end
        s.value = blank ? BLANK_VALUE : running_sum;
        s.blank = blank;
        s.last = last;
        expected_samples.push_back(s);
    endfunction

    // Offer one item, with a random gap first, and hold it until taken.
    task automatic send_item(input logic rtype, input logic [CODE_W-1:0] code,
                             input logic [VALUE_W-1:0] load_value);
        logic taken;
        taken = 1'b0;
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge i_clk);
        end
        in_valid <= 1'b1;
        req_type <= rtype;
        diff_code <= code;
        start_value <= load_value;
        // Ready is settled by mid-cycle; sample it there.
        while (!taken) begin
            @(negedge i_clk);
            taken = in_ready;
            @(posedge i_clk);
        end
        restore_sample(rtype, code, load_value);
    endtask

    // Drop valid and wait until every sample is back and loads have passed.
    task automatic drain_pipeline();
        in_valid <= 1'b0;
        while (expected_samples.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic index, input logic [CFG_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
        if (index == REG_SAMPLES_PER_AXIS)
            spa_reg = data[SPA_W-1:0];
        else
            run_reg = data[RUN_W-1:0];
    endtask

    // Compare each sample taken from the block with the oldest prediction.
    always @(negedge i_clk) begin
        t_sample want;
        if (i_rst_n && out_valid && out_ready) begin
            if (expected_samples.size() == 0) begin
                mismatches = mismatches + 1;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected sample: value %h blank %b end %b",
                             sample_value, is_blank, axis_end);
            end else begin
                want = expected_samples.pop_front();
                if (sample_value !== want.value || is_blank !== want.blank ||
                    axis_end !== want.last) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= REPORT_LIMIT)
                        $display("sample mismatch: expected %h/%b/%b, got %h/%b/%b",
                                 want.value, want.blank, want.last,
                                 sample_value, is_blank, axis_end);
                end
            end
        end
    end

    // Extremes of the table, wrap of the sum both ways, and a true sum equal
    // to the blank value, all under the reset configuration.
    task automatic test_code_table();
        send_item(REQ_LOAD, 8'd0, 32'h7FFF_FFFF);
        send_item(REQ_SAMPLE, 8'd255, '0);
        send_item(REQ_SAMPLE, 8'd128, '0);
        send_item(REQ_SAMPLE, 8'd129, '0);
        send_item(REQ_SAMPLE, 8'd127, '0);
        send_item(REQ_SAMPLE, 8'd1, '0);
        send_item(REQ_LOAD, 8'd0, 32'h8000_0000);
        send_item(REQ_SAMPLE, 8'd1, '0);
        send_item(REQ_LOAD, 8'd0, BLANK_VALUE);
        send_item(REQ_SAMPLE, 8'd128, '0);
        send_item(REQ_SAMPLE, 8'd0, '0);
        send_item(REQ_SAMPLE, 8'd64, '0);
        send_item(REQ_SAMPLE, 8'd192, '0);
        drain_pipeline();
    endtask

    // Blank runs: a zero code inside a run, and a run cut off by the axis end.
    task automatic test_blank_runs();
        write_register(REG_BLANK_RUN_LENGTH, CFG_W'(3));
        write_register(REG_SAMPLES_PER_AXIS, CFG_W'(4));
        send_item(REQ_LOAD, 8'd0, '0);
        send_item(REQ_SAMPLE, 8'd0, '0);
        send_item(REQ_SAMPLE, 8'd0, '0);
        send_item(REQ_SAMPLE, 8'd200, '0);
        send_item(REQ_SAMPLE, 8'd50, '0);
        drain_pipeline();
        write_register(REG_BLANK_RUN_LENGTH, CFG_W'(255));
        write_register(REG_SAMPLES_PER_AXIS, CFG_W'(2));
        send_item(REQ_SAMPLE, 8'd0, '0);
        send_item(REQ_SAMPLE, 8'd10, '0);
        send_item(REQ_SAMPLE, 8'd10, '0);
        drain_pipeline();
    endtask

    // Zero in both registers, then a one-sample axis with the longest run.
    task automatic test_degenerate_config();
        write_register(REG_SAMPLES_PER_AXIS, '0);
        write_register(REG_BLANK_RUN_LENGTH, 16'hFF00);
        send_item(REQ_SAMPLE, 8'd0, '0);
        send_item(REQ_SAMPLE, 8'd255, '0);
        drain_pipeline();
        write_register(REG_SAMPLES_PER_AXIS, CFG_W'(1));
        write_register(REG_BLANK_RUN_LENGTH, CFG_W'(255));
        send_item(REQ_SAMPLE, 8'd0, '0);
        send_item(REQ_SAMPLE, 8'd5, '0);
        drain_pipeline();
    endtask

    // Random traffic under four idling phases, two configurations per phase.
    task automatic test_random_traffic();
        int               idle_pct[4];
        int               stall_pct[4];
        int               pick;
        logic [SPA_W-1:0] spa;
        logic [RUN_W-1:0] run;
        logic [VALUE_W-1:0] load_value;
        idle_pct = '{0, 52, 0, 10};
        stall_pct = '{0, 0, 52, 10};
        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct = idle_pct[phase];
            recv_stall_pct = stall_pct[phase];
            for (int block = 0; block < 2; block++) begin
                // Mostly short axes so axis ends come often; now and then the extremes.
                pick = $urandom_range(99);
                if (pick < 15)
                    spa = SPA_W'(1);
                else if (pick < 25)
                    spa = '1;
                else if (pick < 30)
                    spa = '0;
                else
                    spa = SPA_W'($urandom_range(24, 2));
                pick = $urandom_range(99);
                if (pick < 10)
                    run = '1;
                else if (pick < 15)
                    run = '0;
                else if (pick < 25)
                    run = RUN_W'(1);
                else
                    run = RUN_W'($urandom_range(8, 2));
                write_register(REG_SAMPLES_PER_AXIS, spa);
                write_register(REG_BLANK_RUN_LENGTH, {8'($urandom), run});
                for (int n = 0; n < 250; n++) begin
                    pick = $urandom_range(99);
                    if (pick < 8) begin
                        case ($urandom_range(4))
                            0:       load_value = 32'h7FFF_FFFF;
                            1:       load_value = 32'h8000_0000;
                            2:       load_value = BLANK_VALUE;
                            default: load_value = $urandom;
                        endcase
                        send_item(REQ_LOAD, 8'($urandom), load_value);
                    end else if (pick < 20) begin
                        send_item(REQ_SAMPLE, 8'd0, $urandom);
                    end else begin
                        send_item(REQ_SAMPLE, 8'($urandom_range(255)), $urandom);
                    end
                end
                drain_pipeline();
            end
        end
        // Leave with the longest axis to cover the top of the register.
        write_register(REG_SAMPLES_PER_AXIS, '1);
        write_register(REG_BLANK_RUN_LENGTH, CFG_W'(1));
        for (int n = 0; n < 40; n++)
            send_item(REQ_SAMPLE, 8'($urandom_range(255)), '0);
        drain_pipeline();
    endtask

    initial begin
        // Reset state and register defaults, as the block comes out of reset.
        running_sum = '0;
        blank_left = '0;
        axis_pos = '0;
        spa_reg = '1;
        run_reg = RUN_W'(1);
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_code_table();
        test_blank_runs();
        test_degenerate_config();
        test_random_traffic();
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/ldsd_pkg.sv
rtl/ldsd_delta.sv
rtl/ldsd_seq.sv
rtl/log_delta_sample_decoder_unit.sv
tb/testbench.sv
